### src/marf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist and rate filter package
// Shared types, table sizes and request codes.
// ----------------------------------------------------------------------------
package marf_pkg;

    localparam int ALLOW_SLOTS    = 16;
    localparam int INTERVAL_SLOTS = 8;
    localparam int FLOW_SLOTS     = 16;
    localparam int ALLOW_IDX_W    = $clog2(ALLOW_SLOTS);
    localparam int IV_IDX_W       = $clog2(INTERVAL_SLOTS);
    localparam int FLOW_IDX_W     = $clog2(FLOW_SLOTS);

    typedef enum logic [2:0] {
        REQ_MSG         = 3'd0,
        REQ_WR_ALLOW    = 3'd1,
        REQ_WR_INTERVAL = 3'd2,
        REQ_CLR_INTERVAL = 3'd3,
        REQ_CLR_ALLOW   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_ALLOW = 2'd1,
        CAUSE_RATE  = 2'd2
    } cause_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] msg_id;
        logic [7:0]  entity;
        logic [47:0] now;
        logic [3:0]  slot;
        logic        rule_valid;
        logic        entity_known;
        logic [31:0] interval;
    } item_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic decide;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_msg;
    } status_t;

endpackage
`default_nettype wire

### src/marf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist and rate filter datapath
// Rule tables, flow table and the decision logic over a captured item.
// ----------------------------------------------------------------------------
module marf_datapath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  marf_pkg::item_t      item_in,
    input  marf_pkg::cmd_t       cmd,
    output marf_pkg::status_t    status,
    output logic                 res_dropped,
    output logic [1:0]           res_cause,
    output logic                 res_overflow
);
    import marf_pkg::*;

    item_t item_reg;

    logic [ALLOW_SLOTS-1:0]    al_valid_reg, al_known_reg;
    logic [15:0]               al_id_reg  [ALLOW_SLOTS];
    logic [7:0]                al_ent_reg [ALLOW_SLOTS];
    logic [INTERVAL_SLOTS-1:0] iv_valid_reg;
    logic [15:0]               iv_id_reg  [INTERVAL_SLOTS];
    logic [31:0]               iv_val_reg [INTERVAL_SLOTS];
    logic [FLOW_SLOTS-1:0]     fl_valid_reg;
    logic [15:0]               fl_id_reg  [FLOW_SLOTS];
    logic [7:0]                fl_ent_reg [FLOW_SLOTS];
    logic [47:0]               fl_last_reg [FLOW_SLOTS];

    logic listed, matched, rule_found, hit_found, free_found;
    logic [31:0] rule_ivl;
    logic [FLOW_IDX_W-1:0] hit_idx, free_idx;
    logic [ALLOW_IDX_W-1:0] al_idx;
    logic [IV_IDX_W-1:0] iv_idx;
    logic [47:0] last;
    logic [48:0] deadline;
    logic drop_allow, drop_rate, do_update, do_alloc, ovf;

    assign al_idx = item_reg.slot[ALLOW_IDX_W-1:0];
    assign iv_idx = item_reg.slot[IV_IDX_W-1:0];

    always_comb begin
        listed = 1'b0;
        matched = 1'b0;
        for (int i = 0; i < ALLOW_SLOTS; i++) begin
            if (al_valid_reg[i] && al_id_reg[i] == item_reg.msg_id) begin
                listed = 1'b1;
                if (al_known_reg[i] && al_ent_reg[i] == item_reg.entity) matched = 1'b1;
            end
        end
    end

    // The lowest-numbered matching interval slot rules.
    always_comb begin
        rule_found = 1'b0;
        rule_ivl = '0;
        for (int i = INTERVAL_SLOTS - 1; i >= 0; i--) begin
            if (iv_valid_reg[i] && iv_id_reg[i] == item_reg.msg_id) begin
                rule_found = 1'b1;
                rule_ivl = iv_val_reg[i];
            end
        end
    end

    always_comb begin
        hit_found = 1'b0;
        free_found = 1'b0;
        hit_idx = '0;
        free_idx = '0;
        for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
            if (fl_valid_reg[i]) begin
                if (fl_id_reg[i] == item_reg.msg_id && fl_ent_reg[i] == item_reg.entity) begin
                    hit_found = 1'b1;
                    hit_idx = FLOW_IDX_W'(i);
                end
            end else begin
                free_found = 1'b1;
                free_idx = FLOW_IDX_W'(i);
            end
        end
    end

    always_comb begin
        last = hit_found ? fl_last_reg[hit_idx] : 48'd0;
        deadline = {1'b0, last} + {17'd0, rule_ivl};
        drop_allow = listed && !matched;
        drop_rate = !drop_allow && rule_found && (deadline > {1'b0, item_reg.now});
        do_update = !drop_allow && rule_found && !drop_rate && hit_found;
        do_alloc = !drop_allow && rule_found && !drop_rate && !hit_found && free_found;
        ovf = !drop_allow && rule_found && !drop_rate && !hit_found && !free_found;
    end

    assign status.is_msg = (item_reg.req_type == REQ_MSG);

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= item_in;
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            if (item_reg.req_type == REQ_MSG) begin
                res_dropped  <= drop_allow || drop_rate;
                res_cause    <= drop_allow ? CAUSE_ALLOW : (drop_rate ? CAUSE_RATE : CAUSE_NONE);
                res_overflow <= ovf;
            end else begin
                res_dropped  <= 1'b0;
                res_cause    <= CAUSE_NONE;
                res_overflow <= 1'b0;
            end
        end
    end

    // Payload of the tables.
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            if (item_reg.req_type == REQ_WR_ALLOW && 32'(item_reg.slot) < ALLOW_SLOTS) begin
                al_id_reg[al_idx]  <= item_reg.msg_id;
                al_ent_reg[al_idx] <= item_reg.entity;
            end
            if (item_reg.req_type == REQ_WR_INTERVAL && 32'(item_reg.slot) < INTERVAL_SLOTS) begin
                iv_id_reg[iv_idx]  <= item_reg.msg_id;
                iv_val_reg[iv_idx] <= item_reg.interval;
            end
            if (item_reg.req_type == REQ_MSG && do_update) fl_last_reg[hit_idx] <= item_reg.now;
            if (item_reg.req_type == REQ_MSG && do_alloc) begin
                fl_last_reg[free_idx] <= item_reg.now;
                fl_id_reg[free_idx]   <= item_reg.msg_id;
                fl_ent_reg[free_idx]  <= item_reg.entity;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            al_valid_reg <= '0;
            al_known_reg <= '0;
            iv_valid_reg <= '0;
            fl_valid_reg <= '0;
        end else if (cmd.decide) begin
            unique case (item_reg.req_type)
                REQ_MSG: begin
                    if (do_alloc) fl_valid_reg[free_idx] <= 1'b1;
                end
                REQ_WR_ALLOW: begin
                    if (32'(item_reg.slot) < ALLOW_SLOTS) begin
                        al_valid_reg[al_idx] <= item_reg.rule_valid;
                        al_known_reg[al_idx] <= item_reg.entity_known;
                    end
                end
                REQ_WR_INTERVAL: begin
                    if (32'(item_reg.slot) < INTERVAL_SLOTS)
                        iv_valid_reg[iv_idx] <= item_reg.rule_valid;
                end
                REQ_CLR_INTERVAL: begin
                    iv_valid_reg <= '0;
                    fl_valid_reg <= '0;
                end
                REQ_CLR_ALLOW: al_valid_reg <= '0;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### src/marf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist and rate filter controller
// Sequences capture, decision and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module marf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  marf_pkg::status_t  status,
    output marf_pkg::cmd_t     cmd
);
    import marf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECIDE = 3'b010,
        ST_OUT    = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // The result register is free when empty or being emptied this cycle.
    always_comb begin
        s_tready = (state_reg == ST_IDLE) || (state_reg == ST_OUT && m_tready);
        m_tvalid = (state_reg == ST_OUT);
        cmd.capture = s_tvalid && s_tready;
        cmd.decide = (state_reg == ST_DECIDE);
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) state_next = s_tvalid ? ST_DECIDE : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    logic unused_status;
    assign unused_status = status.is_msg;

endmodule
`default_nettype wire

### src/message_allowlist_rate_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Message allowlist and rate filter
// Drops messages by per-type entity allowlist and per-flow minimum interval.
// ----------------------------------------------------------------------------
// Each item is first captured, then compared against all rule and flow slots
// in parallel and the flow timer updated, after which the result waits in the
// output register; the next item is captured at the edge that hands the result
// off, so no new item is taken while one is being decided.
module message_allowlist_rate_filter_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: msg_id[15:0], entity[23:16], now[71:24], slot[75:72], rule_valid[76],
    // entity_known[77], interval[109:78], zero pad [111:110]
    input  wire logic [111:0] s_tdata,
    // tuser: req_type[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: dropped[0], drop_cause[2:1], timer_overflow[3], zero pad [7:4]
    output logic [7:0]        m_tdata
);
    import marf_pkg::*;

    item_t   item;
    cmd_t    cmd;
    status_t status;
    logic       res_dropped, res_overflow;
    logic [1:0] res_cause;

    always_comb begin
        item.req_type     = s_tuser;
        item.msg_id       = s_tdata[15:0];
        item.entity       = s_tdata[23:16];
        item.now          = s_tdata[71:24];
        item.slot         = s_tdata[75:72];
        item.rule_valid   = s_tdata[76];
        item.entity_known = s_tdata[77];
        item.interval     = s_tdata[109:78];
    end

    marf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd)
    );

    marf_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .item_in(item), .cmd(cmd), .status(status),
        .res_dropped(res_dropped), .res_cause(res_cause), .res_overflow(res_overflow)
    );

    assign m_tdata = {4'd0, res_overflow, res_cause, res_dropped};

endmodule
`default_nettype wire

### src/marf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allowlist and rate filter checker
// Port-level properties of the filter.
// ----------------------------------------------------------------------------
module marf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);
    a_ovf_not_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[0]) else $error("overflow on a dropped item");
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != 2'd0)) && m_tdata[2:1] != 2'd3)
        else $error("cause inconsistent with dropped");
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid) else $error("result missing");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
endmodule

bind message_allowlist_rate_filter_top marf_checker u_marf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
